// File: hdl/lkm_pkg.sv
// Shared types, codes and sizes for the reader/writer lock manager.
package lkm_pkg;

    localparam int REQUESTERS  = 16;
    localparam int QUEUE_DEPTH = 16;

    localparam int OP_W  = 3;
    localparam int ID_W  = 4;
    localparam int STS_W = 3;
    localparam int SO_W  = 5;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SO_W-1:0] SHARED_MAX = 5'd31;

    localparam logic [OP_W-1:0] OP_ACQ_SH = 3'd0;
    localparam logic [OP_W-1:0] OP_ACQ_EX = 3'd1;
    localparam logic [OP_W-1:0] OP_TRY_SH = 3'd2;
    localparam logic [OP_W-1:0] OP_TRY_EX = 3'd3;
    localparam logic [OP_W-1:0] OP_REL_SH = 3'd4;
    localparam logic [OP_W-1:0] OP_REL_EX = 3'd5;

    localparam logic [STS_W-1:0] STS_GRANTED  = 3'd0;
    localparam logic [STS_W-1:0] STS_REFUSED  = 3'd1;
    localparam logic [STS_W-1:0] STS_QUEUED   = 3'd2;
    localparam logic [STS_W-1:0] STS_RELEASED = 3'd3;
    localparam logic [STS_W-1:0] STS_ERROR    = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WAKE   = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            excl;
    } t_waiter;

    typedef struct packed {
        logic    push;
        logic    pop;
        t_waiter data;
    } t_queue_ctl;

    typedef struct packed {
        t_waiter          head;
        logic [CNT_W-1:0] count;
    } t_queue_sts;

    typedef enum logic {
        ST_IDLE,
        ST_WAKE
    } t_state;

endpackage

// File: hdl/lkm_cell.sv
// One wait queue cell: holds a waiter and takes its neighbor's waiter on a pop.
module lkm_cell (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_shift,
    input  lkm_pkg::t_waiter i_new,
    input  lkm_pkg::t_waiter i_next,
    output lkm_pkg::t_waiter o_data
);
    import lkm_pkg::*;

    t_waiter r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_new;
        end else if (i_shift) begin
            r_data <= i_next;
        end
    end

    assign o_data = r_data;

endmodule

// File: hdl/lkm_queue.sv
// Wait queue built as a chain of cells with the oldest waiter in the first cell.
module lkm_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lkm_pkg::t_queue_ctl i_ctl,
    output lkm_pkg::t_queue_sts o_sts
);
    import lkm_pkg::*;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    t_waiter                w_cell [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_load;

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
            t_waiter w_next;
            if (k == QUEUE_DEPTH - 1) begin : g_end
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_cell[k+1];
            end
            assign w_load[k] = i_ctl.push && (r_count == CNT_W'(k));
            lkm_cell u_cell (
                .i_clk   (i_clk),
                .i_load  (w_load[k]),
                .i_shift (i_ctl.pop),
                .i_new   (i_ctl.data),
                .i_next  (w_next),
                .o_data  (w_cell[k])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_sts.head  = w_cell[0];
    assign o_sts.count = r_count;

endmodule

// File: hdl/reader_writer_lock_manager_unit.sv
// Top level of the reader/writer lock manager with its FIFO wait queue.
// Each accepted request yields its status word in the next cycle from the output register;
// a request that causes no wakeup frees the input side again as soon as that word is
// taken, so such requests can follow one per cycle. A request that runs the wake policy
// then sends wake notices, which leave the head cell of the wait queue one per cycle
// while the output is not stalled, as the cells shift toward the head; no request is
// taken during that walk.
module reader_writer_lock_manager_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [lkm_pkg::OP_W-1:0]  i_operation,
    input  logic [lkm_pkg::ID_W-1:0]  i_requester,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_result_kind,
    output logic [lkm_pkg::STS_W-1:0] o_status,
    output logic [lkm_pkg::ID_W-1:0]  o_target,
    output logic                      o_last
);
    import lkm_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic             r_wake_all;
    logic             r_held;
    logic             r_contended;
    logic [SO_W-1:0]  r_shared;
    logic [SO_W-1:0]  r_displaced;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_out_kind;
    logic             n_out_kind;
    logic [STS_W-1:0] r_out_status;
    logic [STS_W-1:0] n_out_status;
    logic [ID_W-1:0]  r_out_target;
    logic [ID_W-1:0]  n_out_target;
    logic             r_out_last;
    logic             n_out_last;

    logic             w_accept;
    logic             w_out_free;
    logic             w_wake_last;
    t_queue_ctl       w_qctl;
    t_queue_sts       w_qsts;

    logic [STS_W-1:0] d_status;
    logic             d_push;
    logic             d_push_excl;
    logic             d_run;
    logic             d_held;
    logic             d_cont;
    logic [SO_W-1:0]  d_shared;
    logic [SO_W-1:0]  d_disp;

    logic [CNT_W-1:0] w_cnt_after;
    logic             w_head_excl;
    logic             w_wake_one;
    logic             w_wake_all;
    logic             f_held;
    logic             f_cont;
    logic [SO_W-1:0]  f_shared;
    logic [SO_W-1:0]  f_disp;

    lkm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .o_sts   (w_qsts)
    );

    assign w_out_free  = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != ST_IDLE) || (r_out_valid && i_stall);
    assign w_accept    = i_valid && !o_stall;
    assign w_wake_last = !r_wake_all || (w_qsts.count == CNT_W'(1));

    always_comb begin
        logic is_try;
        logic is_full;
        logic last_owner;
        is_try      = (i_operation == OP_TRY_SH) || (i_operation == OP_TRY_EX);
        is_full     = (w_qsts.count >= CNT_W'(QUEUE_DEPTH));
        last_owner  = 1'b1;
        d_status    = STS_ERROR;
        d_push      = 1'b0;
        d_push_excl = 1'b0;
        d_run       = 1'b0;
        d_held      = r_held;
        d_cont      = r_contended;
        d_shared    = r_shared;
        d_disp      = r_displaced;
        if (int'(i_requester) >= REQUESTERS || i_operation > OP_REL_EX) begin
            d_status = STS_ERROR;
        end else begin
            case (i_operation)
                OP_ACQ_SH, OP_TRY_SH: begin
                    if (!r_contended && (!r_held || r_shared != '0)) begin
                        if (r_shared >= SHARED_MAX) begin
                            d_status = STS_ERROR;
                        end else begin
                            d_held   = 1'b1;
                            d_shared = r_shared + SO_W'(1);
                            d_status = STS_GRANTED;
                        end
                    end else if (is_try) begin
                        d_status = STS_REFUSED;
                    end else if (is_full) begin
                        d_status = STS_ERROR;
                    end else begin
                        if (!r_contended) begin
                            d_cont = 1'b1;
                            d_disp = (r_shared > SO_W'(1)) ? r_shared : '0;
                        end
                        d_push   = 1'b1;
                        d_status = STS_QUEUED;
                        d_run    = !r_held;
                    end
                end
                OP_ACQ_EX, OP_TRY_EX: begin
                    if (!r_held) begin
                        d_held   = 1'b1;
                        d_shared = '0;
                        d_status = STS_GRANTED;
                    end else if (is_try) begin
                        d_status = STS_REFUSED;
                    end else if (is_full) begin
                        d_status = STS_ERROR;
                    end else begin
                        if (!r_contended) begin
                            d_cont = 1'b1;
                            d_disp = (r_shared > SO_W'(1)) ? r_shared : '0;
                        end
                        d_push      = 1'b1;
                        d_push_excl = 1'b1;
                        d_status    = STS_QUEUED;
                    end
                end
                OP_REL_SH: begin
                    if (!r_held || r_shared == '0) begin
                        d_status = STS_ERROR;
                    end else if (!r_contended) begin
                        d_shared = r_shared - SO_W'(1);
                        d_held   = (r_shared != SO_W'(1));
                        d_status = STS_RELEASED;
                    end else begin
                        d_shared = r_shared - SO_W'(1);
                        if (r_displaced != '0) begin
                            d_disp     = r_displaced - SO_W'(1);
                            last_owner = (r_displaced == SO_W'(1));
                        end
                        d_status = STS_RELEASED;
                        if (last_owner) begin
                            d_held   = 1'b0;
                            d_shared = '0;
                            d_run    = 1'b1;
                        end
                    end
                end
                OP_REL_EX: begin
                    if (!r_held || r_shared != '0) begin
                        d_status = STS_ERROR;
                    end else begin
                        d_held   = 1'b0;
                        d_status = STS_RELEASED;
                        d_run    = r_contended;
                    end
                end
                default: begin
                    d_status = STS_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        w_cnt_after = w_qsts.count + CNT_W'(d_push);
        w_head_excl = (w_qsts.count == '0) ? d_push_excl : w_qsts.head.excl;
        w_wake_one  = d_run && (w_cnt_after > CNT_W'(1)) && w_head_excl;
        w_wake_all  = d_run && (w_cnt_after != '0) && !w_wake_one;
        f_held      = d_held;
        f_cont      = d_cont;
        f_shared    = d_shared;
        f_disp      = d_disp;
        if (d_run && w_cnt_after == '0) begin
            f_cont = 1'b0;
            f_disp = '0;
        end else if (w_wake_all) begin
            f_held   = 1'b0;
            f_cont   = 1'b0;
            f_shared = '0;
            f_disp   = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_wake_one || w_wake_all)) begin
                    n_state = ST_WAKE;
                end
            end
            ST_WAKE: begin
                if (w_out_free && w_wake_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid    = r_out_valid && i_stall;
        n_out_kind     = r_out_kind;
        n_out_status   = r_out_status;
        n_out_target   = r_out_target;
        n_out_last     = r_out_last;
        w_qctl.push    = 1'b0;
        w_qctl.pop     = 1'b0;
        w_qctl.data.id = i_requester;
        w_qctl.data.excl = d_push_excl;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_STATUS;
                    n_out_status = d_status;
                    n_out_target = i_requester;
                    n_out_last   = !(w_wake_one || w_wake_all);
                    w_qctl.push  = d_push;
                end
            end
            ST_WAKE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_WAKE;
                    n_out_status = STS_GRANTED;
                    n_out_target = w_qsts.head.id;
                    n_out_last   = w_wake_last;
                    w_qctl.pop   = 1'b1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wake_all  <= 1'b0;
            r_held      <= 1'b0;
            r_contended <= 1'b0;
            r_shared    <= '0;
            r_displaced <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_accept) begin
                r_wake_all  <= w_wake_all;
                r_held      <= f_held;
                r_contended <= f_cont;
                r_shared    <= f_shared;
                r_displaced <= f_disp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_target <= n_out_target;
        r_out_last   <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_status      = r_out_status;
    assign o_target      = r_out_target;
    assign o_last        = r_out_last;

endmodule

// File: hdl/lkm_checker.sv
// Port-level checks on the lock manager and their attachment to the top level.
module lkm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic [lkm_pkg::ID_W-1:0]  i_requester,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic                      o_result_kind,
    input logic [lkm_pkg::STS_W-1:0] o_status,
    input logic [lkm_pkg::ID_W-1:0]  o_target,
    input logic                      o_last
);
    import lkm_pkg::*;

    a_stalled_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_target) && $stable(o_status)
            && $stable(o_result_kind) && $stable(o_last))
        else $error("stalled output word changed");

    a_accept_gives_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid && o_result_kind == KIND_STATUS
            && o_target == $past(i_requester))
        else $error("accepted request did not produce its status word");

    a_no_accept_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input open while wake notices are pending");

    a_wake_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_WAKE |-> o_status == STS_GRANTED)
        else $error("wake notice carries a nonzero status");

    a_final_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_STATUS && o_status != STS_QUEUED
            && o_status != STS_RELEASED |-> o_last)
        else $error("status word that cannot wake anyone is not last");

endmodule

bind reader_writer_lock_manager_unit lkm_checker u_lkm_checker (.*);
